// ----- rtl/dtmi_pkg.sv -----
`timescale 1ns / 1ps
package dtmi_pkg;

	// Default geometry of the map store.
	localparam int MAP_COUNT_DEF   = 8;
	localparam int DIST_BINS_DEF   = 38;
	localparam int OFFSET_BINS_DEF = 11;
	localparam int ENTRY_WIDTH_DEF = 16;

	// Stream payload widths.
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 2;
	localparam int CFG_W     = 12;

	// Command codes carried in s_tuser.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Sampled drift velocities in 0.001 cm/us, ascending.
	localparam logic [11:0] VEL_SAMPLES [8] = '{
		12'd1032, 12'd1158, 12'd1299, 12'd1450,
		12'd1610, 12'd1783, 12'd1959, 12'd2134
	};
	localparam int VEL_MIN        = 1032;
	localparam int VEL_MAX        = 2134;
	localparam int NEAR_WIRE_UM   = 50;
	localparam int DIST_STEP_UM   = 1000;
	localparam int OFFSET_STEP_UM = 250;
	localparam int HALF_GAP_RESET = 1750;

	// Width of the narrow multiplier operand (fractions and velocity offset).
	localparam int FRAC_W = 14;
	// Width of every divisor (largest is the distance step).
	localparam int DVW    = 10;

endpackage

// ----- rtl/dtmi_ram.sv -----
`timescale 1ns / 1ps
module dtmi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/drift_time_map_interpolator.sv -----
`timescale 1ns / 1ps
// Channel   | Signals                        | Contents (lowest bit first)
// s (in)    | s_tvalid s_tready s_tdata/user | tuser: command; tdata: map_index, dist_bin,
//           |                                |   offset_bin, entry_value, velocity,
//           |                                |   distance_um, offset_um
// m (out)   | m_tvalid m_tready m_tdata/user | tdata: drift_time; tuser: velocity_clamped,
//           |                                |   offset_clamped
// cfg       | cfg_valid cfg_ready cfg_data   | half_gap_um
//
// A write transfer is stored in the map memory in the cycle it is accepted, so writes
// stream at one per cycle. A query holds the input side closed until its result has
// been loaded into the output register: for each of the two maps, four corner reads
// from the single memory read port and then three multiply and divide operations,
// followed by one last operation, seven in all, each on one shared multiplier and an
// 8 bit per cycle long divider that shifts each quotient into its numerator register.
// Reset is asynchronous and active low; it clears the sequencer and the output valid and
// loads half_gap_um with 1750. The map memory is not cleared. A finished result waits in
// the output register while a stalled m_tready holds it, and the next transfer is taken
// as soon as the sequencer is back in idle.
module drift_time_map_interpolator
	import dtmi_pkg::*;
#(
	parameter int MAP_COUNT   = MAP_COUNT_DEF,
	parameter int DIST_BINS   = DIST_BINS_DEF,
	parameter int OFFSET_BINS = OFFSET_BINS_DEF,
	parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// map_index[2:0] dist_bin[8:3] offset_bin[12:9] entry_value[28:13] velocity[40:29]
	// distance_um[53:41] offset_um[65:54], zero padding above
	input  logic [S_TDATA_W-1:0] s_tdata,
	// command[0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// drift_time[31:0]
	output logic [M_TDATA_W-1:0] m_tdata,
	// velocity_clamped[0] offset_clamped[1]
	output logic [M_TUSER_W-1:0] m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH     = MAP_COUNT * DIST_BINS * OFFSET_BINS;
	localparam int AW        = $clog2(DEPTH);
	localparam int DBW       = $clog2(DIST_BINS);
	localparam int OBW       = $clog2(OFFSET_BINS);
	localparam int DW        = ENTRY_WIDTH + 24;
	localparam int PW        = DW + FRAC_W;
	localparam int PWP       = ((PW + 7) / 8) * 8;
	localparam int DIV_STEPS = PWP / 8;
	localparam int DCW       = $clog2(DIV_STEPS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_ADD   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	localparam logic [1:0] OP_Y1 = 2'd0;
	localparam logic [1:0] OP_Y2 = 2'd1;
	localparam logic [1:0] OP_M  = 2'd2;
	localparam logic [1:0] OP_T  = 2'd3;

	// Control state.
	logic [2:0]     state_q;
	logic [1:0]     op_q;
	logic           map_sel_q;
	logic [2:0]     rd_cnt_q;
	logic [DCW-1:0] div_cnt_q;
	logic           m_tvalid_q;
	logic [11:0]    half_gap_q;

	// Query fields.
	logic [11:0]        vel_q;
	logic signed [12:0] dist_q;
	logic [11:0]        off_q;

	// Values fixed for the whole query.
	logic [2:0]              lo_q, hi_q;
	logic [DBW-1:0]          r1_q, r2_q, c3row_q;
	logic [OBW-1:0]          k1_q, c2col_q;
	logic signed [FRAC_W-1:0] fd_q, fz_q, dv_q;
	logic [DVW-1:0]          den_q;
	logic                    active_q, vflag_q, oflag_q;

	// Datapath.
	logic [ENTRY_WIDTH-1:0] corner_q [4];
	logic signed [DW-1:0]   y1_q, y2_q, m_lo_q, m_hi_q, base_q;
	logic [PWP-1:0]         num_q;
	logic [DVW-1:0]         rem_q, divisor_q;
	logic                   sign_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;
	logic [M_TUSER_W-1:0]   m_tuser_q;

	logic                   s_xfer;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr, rd_addr;
	logic [ENTRY_WIDTH-1:0] rd_data;
	logic [2:0]             rd_map;
	logic                   map_ok;
	logic                   out_free;

	function automatic logic [AW-1:0] entry_addr(input int map, input int row, input int col);
		int full;
		full = (map * DIST_BINS + row) * OFFSET_BINS + col;
		return AW'(full);
	endfunction

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	// Writes go straight to memory when in range; anything past the store is dropped.
	always_comb begin
		wr_en = s_xfer && (s_tuser[0] == CMD_WRITE)
			&& (int'(s_tdata[2:0]) < MAP_COUNT)
			&& (int'(s_tdata[8:3]) < DIST_BINS)
			&& (int'(s_tdata[12:9]) < OFFSET_BINS);
		wr_addr = entry_addr(int'(s_tdata[2:0]), int'(s_tdata[8:3]), int'(s_tdata[12:9]));
	end

	// Corner read address. A map that is not stored reads as zero.
	assign rd_map = map_sel_q ? hi_q : lo_q;
	assign map_ok = int'(rd_map) < MAP_COUNT;

	always_comb begin
		case (rd_cnt_q[1:0])
			2'd0:    rd_addr = entry_addr(int'(rd_map), int'(r1_q), int'(k1_q));
			2'd1:    rd_addr = entry_addr(int'(rd_map), int'(r2_q), int'(k1_q));
			2'd2:    rd_addr = entry_addr(int'(rd_map), int'(r1_q), int'(c2col_q));
			default: rd_addr = entry_addr(int'(rd_map), int'(c3row_q), int'(c2col_q));
		endcase
		if (!map_ok) begin
			rd_addr = '0;
		end
	end

	dtmi_ram #(
		.WIDTH(ENTRY_WIDTH),
		.DEPTH(DEPTH)
	) u_map_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(ENTRY_WIDTH'(s_tdata[28:13])),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Query setup: map bracket, bins, fractions and the near-wire test.
	logic [2:0]               lo_d;
	logic [DBW-1:0]           r1_d, r2_d, c3row_d;
	logic [OBW-1:0]           k1_d, c2col_d;
	logic signed [FRAC_W-1:0] fd_d, fz_d, dv_d;
	logic [DVW-1:0]           den_d;
	logic                     active_d, vflag_d, oflag_d;

	always_comb begin
		int vc, dist_um, off, r1, k1, rel, hi;
		vc      = int'(vel_q);
		dist_um = int'(dist_q);
		off     = int'(off_q);
		vflag_d = 1'b0;
		if (vc < VEL_MIN) begin
			vc = VEL_MIN;
			vflag_d = 1'b1;
		end else if (vc > VEL_MAX) begin
			vc = VEL_MAX;
			vflag_d = 1'b1;
		end
		lo_d = 3'd0;
		for (int i = 1; i <= 6; i++) begin
			if (vc > int'(VEL_SAMPLES[i])) begin
				lo_d = 3'(i);
			end
		end
		hi = int'(lo_d) + 1;
		r1 = 0;
		for (int j = 1; j <= 4; j++) begin
			if (dist_um >= j * DIST_STEP_UM) begin
				r1 = j;
			end
		end
		if (r1 > DIST_BINS - 1) begin
			r1 = DIST_BINS - 1;
		end
		k1 = 0;
		for (int j = 1; j <= 16; j++) begin
			if (off >= j * OFFSET_STEP_UM) begin
				k1 = j;
			end
		end
		oflag_d = 1'b0;
		if (k1 > OFFSET_BINS - 1) begin
			k1 = OFFSET_BINS - 1;
			oflag_d = 1'b1;
		end
		r1_d = DBW'(r1);
		r2_d = (r1 + 1 > DIST_BINS - 1) ? DBW'(DIST_BINS - 1) : DBW'(r1 + 1);
		k1_d = OBW'(k1);
		// Past the last offset bin the far corners fold onto the table edge.
		if (k1 + 1 <= OFFSET_BINS - 1) begin
			c2col_d = OBW'(k1 + 1);
			c3row_d = r2_d;
		end else begin
			c2col_d = OBW'(OFFSET_BINS - 1);
			c3row_d = DBW'(DIST_BINS - 1);
		end
		fd_d  = FRAC_W'(dist_um - DIST_STEP_UM * r1);
		fz_d  = FRAC_W'(off - OFFSET_STEP_UM * k1);
		dv_d  = FRAC_W'(int'(vel_q) - int'(VEL_SAMPLES[hi[2:0]]));
		den_d = DVW'(int'(VEL_SAMPLES[hi[2:0]]) - int'(VEL_SAMPLES[lo_d]));
		rel = dist_um - int'(half_gap_q);
		if (rel < 0) begin
			rel = -rel;
		end
		active_d = (rel > NEAR_WIRE_UM) || (off > NEAR_WIRE_UM);
	end

	// Operand selection for the shared multiply, divide and add.
	logic signed [DW-1:0] cz [4];
	logic signed [DW-1:0] op_a, op_base;
	logic signed [FRAC_W-1:0] op_b;
	logic [DVW-1:0]       op_div;
	logic signed [PW-1:0] prod;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cz[i] = $signed({{(DW - ENTRY_WIDTH){1'b0}}, corner_q[i]});
		end
		case (op_q)
			OP_Y1: begin
				op_a    = (cz[1] - cz[0]) <<< 8;
				op_b    = fd_q;
				op_div  = DVW'(DIST_STEP_UM);
				op_base = cz[0] <<< 8;
			end
			OP_Y2: begin
				op_a    = (cz[3] - cz[2]) <<< 8;
				op_b    = fd_q;
				op_div  = DVW'(DIST_STEP_UM);
				op_base = cz[2] <<< 8;
			end
			OP_M: begin
				op_a    = y2_q - y1_q;
				op_b    = fz_q;
				op_div  = DVW'(OFFSET_STEP_UM);
				op_base = y1_q;
			end
			default: begin
				op_a    = m_hi_q - m_lo_q;
				op_b    = dv_q;
				op_div  = den_q;
				op_base = m_hi_q;
			end
		endcase
		prod = PW'(op_a) * PW'(op_b);
	end

	// Eight steps of restoring long division per cycle; the quotient shifts into num.
	logic [PWP-1:0] num_d;
	logic [DVW-1:0] rem_d;

	always_comb begin
		logic [DVW:0]   r;
		logic [PWP-1:0] n;
		r = {1'b0, rem_q};
		n = num_q;
		for (int j = 0; j < 8; j++) begin
			r = {r[DVW-1:0], n[PWP-1]};
			n = {n[PWP-2:0], 1'b0};
			if (r >= {1'b0, divisor_q}) begin
				r = r - {1'b0, divisor_q};
				n[0] = 1'b1;
			end
		end
		num_d = n;
		rem_d = r[DVW-1:0];
	end

	// Signed result of the current operation, quotient truncated toward zero, and the
	// final sum saturated to the 32 bit result.
	logic signed [DW-1:0] quot, op_res;
	logic [M_TDATA_W-1:0] t_sat;

	always_comb begin
		quot   = $signed(num_q[DW-1:0]);
		op_res = op_base + (sign_q ? -quot : quot);
		if (&base_q[DW-1:31] || ~|base_q[DW-1:31]) begin
			t_sat = base_q[31:0];
		end else begin
			t_sat = base_q[DW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_Y1;
			map_sel_q  <= 1'b0;
			rd_cnt_q   <= '0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
			half_gap_q <= 12'(HALF_GAP_RESET);
		end else begin
			if (cfg_valid && cfg_ready) begin
				half_gap_q <= cfg_data;
			end
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_xfer && s_tuser[0] == CMD_QUERY) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					map_sel_q <= 1'b0;
					rd_cnt_q  <= '0;
					state_q   <= ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd4) begin
						op_q    <= OP_Y1;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCW'(DIV_STEPS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					case (op_q)
						OP_Y1: begin
							op_q    <= OP_Y2;
							state_q <= ST_MUL;
						end
						OP_Y2: begin
							op_q    <= OP_M;
							state_q <= ST_MUL;
						end
						OP_M: begin
							if (!map_sel_q) begin
								map_sel_q <= 1'b1;
								rd_cnt_q  <= '0;
								state_q   <= ST_READ;
							end else begin
								op_q    <= OP_T;
								state_q <= ST_MUL;
							end
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			vel_q  <= s_tdata[40:29];
			dist_q <= $signed(s_tdata[53:41]);
			off_q  <= s_tdata[65:54];
		end
		if (state_q == ST_SETUP) begin
			lo_q     <= lo_d;
			hi_q     <= lo_d + 3'd1;
			r1_q     <= r1_d;
			r2_q     <= r2_d;
			c3row_q  <= c3row_d;
			k1_q     <= k1_d;
			c2col_q  <= c2col_d;
			fd_q     <= fd_d;
			fz_q     <= fz_d;
			dv_q     <= dv_d;
			den_q    <= den_d;
			active_q <= active_d;
			vflag_q  <= vflag_d;
			oflag_q  <= oflag_d;
		end
		if (state_q == ST_READ && rd_cnt_q != 3'd0) begin
			corner_q[2'(rd_cnt_q - 3'd1)] <= map_ok ? rd_data : '0;
		end
		if (state_q == ST_MUL) begin
			sign_q    <= prod[PW-1];
			num_q     <= PWP'(prod[PW-1] ? -prod : prod);
			rem_q     <= '0;
			divisor_q <= op_div;
		end
		if (state_q == ST_DIV) begin
			num_q <= num_d;
			rem_q <= rem_d;
		end
		if (state_q == ST_ADD) begin
			case (op_q)
				OP_Y1: y1_q <= op_res;
				OP_Y2: y2_q <= op_res;
				OP_M: begin
					if (!map_sel_q) begin
						m_lo_q <= active_q ? op_res : '0;
					end else begin
						m_hi_q <= active_q ? op_res : '0;
					end
				end
				default: base_q <= op_res;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= t_sat;
			m_tuser_q <= {oflag_q, vflag_q};
		end
	end

endmodule

// ----- rtl/dtmi_checker.sv -----
`timescale 1ns / 1ps
module dtmi_checker
	import dtmi_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TUSER_W-1:0] s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A write transfer never makes a result appear.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == CMD_WRITE && !m_tvalid |=> !m_tvalid)
		else $error("result produced by a write");

	// A query holds the input side closed while it is worked on.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == CMD_QUERY |=> !s_tready)
		else $error("input taken during a query");

	// The result register only fills when the input side is closed.
	a_out_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a query in progress");

endmodule

bind drift_time_map_interpolator dtmi_checker u_dtmi_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ----- test/drift_time_map_interpolator_tb.sv -----
`timescale 1ns / 1ps
module drift_time_map_interpolator_tb;
	import dtmi_pkg::*;

	localparam int N_MAPS   = MAP_COUNT_DEF;
	localparam int N_DIST   = DIST_BINS_DEF;
	localparam int N_OFF    = OFFSET_BINS_DEF;
	localparam int STORE_SZ = N_MAPS * N_DIST * N_OFF;
	localparam int QUERY_LATENCY = 120;
	localparam int STALL_LIMIT   = 5000;

	// One expected query answer.
	typedef struct packed {
		logic [31:0] drift_time;
		logic        vel_clamped;
		logic        off_clamped;
	} drift_answer_t;

	// Predicts drift times from its own copy of the maps and of half_gap_um,
	// and checks answers in order.
	class drift_time_scoreboard;
		logic [15:0]   map_store [STORE_SZ];
		logic [11:0]   half_gap;
		drift_answer_t pending_answers [$];
		int            error_count;

		function new();
			half_gap = 12'(HALF_GAP_RESET);
			error_count = 0;
			foreach (map_store[i]) map_store[i] = '0;
		endfunction

		function longint corner(int map, int db, int ob);
			if (map >= N_MAPS) return 0;
			return longint'(map_store[(map * N_DIST + db) * N_OFF + ob]);
		endfunction

		function longint interp_map(int map, int r1, int r2, int k1, longint fd, longint fz);
			longint c11, c21, c12, c22, y1, y2;
			c11 = corner(map, r1, k1);
			c21 = corner(map, r2, k1);
			if (k1 + 1 <= N_OFF - 1) begin
				c12 = corner(map, r1, k1 + 1);
				c22 = corner(map, r2, k1 + 1);
			end else begin
				// Past the last offset bin the far corners fold onto the table edge.
				c12 = corner(map, r1, N_OFF - 1);
				c22 = corner(map, N_DIST - 1, N_OFF - 1);
			end
			y1 = c11 * 256 + ((c21 - c11) * 256 * fd) / DIST_STEP_UM;
			y2 = c12 * 256 + ((c22 - c12) * 256 * fd) / DIST_STEP_UM;
			return y1 + ((y2 - y1) * fz) / OFFSET_STEP_UM;
		endfunction

		function void note_transfer(logic cmd, logic [71:0] d);
			int map, db, ob, vel, dist_um, off, vc, lo, r1, r2, k1, rel;
			longint fd, fz, m_lo, m_hi, t;
			drift_answer_t a;
			map = int'(d[2:0]);
			db  = int'(d[8:3]);
			ob  = int'(d[12:9]);
			if (cmd == CMD_WRITE) begin
				if (map < N_MAPS && db < N_DIST && ob < N_OFF)
					map_store[(map * N_DIST + db) * N_OFF + ob] = d[28:13];
				return;
			end
			vel     = int'(d[40:29]);
			dist_um = int'($signed(d[53:41]));
			off     = int'(d[65:54]);
			a = '0;
			vc = vel;
			if (vc < VEL_MIN) begin
				vc = VEL_MIN;
				a.vel_clamped = 1'b1;
			end else if (vc > VEL_MAX) begin
				vc = VEL_MAX;
				a.vel_clamped = 1'b1;
			end
			lo = 0;
			for (int i = 6; i >= 1; i--)
				if (lo == 0 && vc > int'(VEL_SAMPLES[i])) lo = i;
			r1 = (dist_um < 0) ? 0 : dist_um / DIST_STEP_UM;
			if (r1 > N_DIST - 1) r1 = N_DIST - 1;
			r2 = (r1 + 1 > N_DIST - 1) ? N_DIST - 1 : r1 + 1;
			k1 = off / OFFSET_STEP_UM;
			if (k1 > N_OFF - 1) begin
				k1 = N_OFF - 1;
				a.off_clamped = 1'b1;
			end
			fd = longint'(dist_um - DIST_STEP_UM * r1);
			fz = longint'(off - OFFSET_STEP_UM * k1);
			rel = dist_um - int'(half_gap);
			if (rel < 0) rel = -rel;
			m_lo = 0;
			m_hi = 0;
			// Close to the anode wire both map values are forced to zero.
			if (rel > NEAR_WIRE_UM || off > NEAR_WIRE_UM) begin
				m_lo = interp_map(lo, r1, r2, k1, fd, fz);
				m_hi = interp_map(lo + 1, r1, r2, k1, fd, fz);
			end
			t = m_hi + ((m_hi - m_lo) * (longint'(vel) - longint'(VEL_SAMPLES[lo + 1])))
				/ longint'(VEL_SAMPLES[lo + 1] - VEL_SAMPLES[lo]);
			if (t > 64'sd2147483647) t = 64'sd2147483647;
			if (t < -64'sd2147483648) t = -64'sd2147483648;
			a.drift_time = t[31:0];
			pending_answers.push_back(a);
		endfunction

		function void check_answer(logic [31:0] dt, logic [1:0] flags);
			drift_answer_t e;
			if (pending_answers.size() == 0) begin
				$error("unexpected result drift_time=%0d", $signed(dt));
				error_count++;
				return;
			end
			e = pending_answers.pop_front();
			if (dt !== e.drift_time) begin
				$error("drift_time expected %0d actual %0d", $signed(e.drift_time), $signed(dt));
				error_count++;
			end
			if (flags[0] !== e.vel_clamped) begin
				$error("velocity_clamped expected %0b actual %0b", e.vel_clamped, flags[0]);
				error_count++;
			end
			if (flags[1] !== e.off_clamped) begin
				$error("offset_clamped expected %0b actual %0b", e.off_clamped, flags[1]);
				error_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [71:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid, cfg_ready;
	logic [11:0] cfg_data;

	drift_time_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	drift_time_map_interpolator u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Result side: the receiver stalls at random, and each accepted transfer is checked.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_answer(m_tdata, m_tuser);
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: ends the run after a long stretch with no transfer on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Presents one transfer and holds it until the block accepts it. tvalid stays high
	// afterwards; the next call swaps it or drops it for a gap; drain() takes it down.
	task automatic send_item(logic cmd, logic [71:0] payload);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= payload;
		do @(posedge clk); while (!s_tready);
		sb.note_transfer(cmd, payload);
		@(negedge clk);
	endtask

	task automatic write_entry(int map, int db, int ob, logic [15:0] value);
		logic [71:0] d;
		d = '0;
		d[2:0]   = 3'(map);
		d[8:3]   = 6'(db);
		d[12:9]  = 4'(ob);
		d[28:13] = value;
		// The query fields are noise for a write.
		d[65:29] = 37'({$urandom, $urandom});
		send_item(CMD_WRITE, d);
	endtask

	task automatic query(logic [11:0] vel, logic [12:0] dist_um, logic [11:0] off);
		logic [71:0] d;
		d = '0;
		d[12:0]  = 13'($urandom);
		d[28:13] = 16'($urandom);
		d[40:29] = vel;
		d[53:41] = dist_um;
		d[65:54] = off;
		send_item(CMD_QUERY, d);
	endtask

	// Closes the input side, waits for every outstanding answer, then covers a query
	// still in flight.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_answers.size() != 0) @(negedge clk);
		repeat (QUERY_LATENCY) @(negedge clk);
	endtask

	task automatic write_half_gap(logic [11:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.half_gap = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random query; distances and offsets lean toward the wire and the table edges.
	task automatic random_query();
		logic [11:0] vel, off;
		logic [12:0] dist_um;
		case ($urandom_range(3))
			0: vel = 12'($urandom);
			default: vel = 12'($urandom_range(VEL_MAX + 40, VEL_MIN - 40));
		endcase
		case ($urandom_range(4))
			0: dist_um = 13'($urandom);
			1: dist_um = 13'(int'(sb.half_gap) + int'($urandom_range(120)) - 60);
			default: dist_um = 13'($urandom_range(4095));
		endcase
		case ($urandom_range(3))
			0: off = 12'($urandom_range(60));
			1: off = 12'($urandom_range(4095, 2500));
			default: off = 12'($urandom);
		endcase
		query(vel, dist_um, off);
	endtask

	initial begin
		logic [11:0] gaps [5];
		int          n;
		gaps = '{12'd1750, 12'd0, 12'd4095, 12'd700, 12'd3000};
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Load every entry a query can reach first: distances below 4096 um only touch
		// bins 0 to 5, and the folded corner touches the last distance bin.
		for (int m = 0; m < N_MAPS; m++)
			for (int db = 0; db < N_DIST; db++)
				if (db <= 5 || db == N_DIST - 1)
					for (int ob = 0; ob < N_OFF; ob++)
						write_entry(m, db, ob, (m == 0 && db == 0 && ob == 0) ? 16'hFFFF :
							(m == 1 && db == 0 && ob == 0) ? 16'h0000 : 16'($urandom));

		// Directed cases: velocity edges, wire zone, negative distance, offset past table.
		query(12'd0, 13'd0, 12'd0);
		query(12'hFFF, 13'h0FFF, 12'hFFF);
		query(12'd1032, 13'd1750, 12'd50);
		query(12'd1033, 13'd1800, 12'd51);
		query(12'd2134, 13'd1699, 12'd0);
		query(12'd1158, -13'sd4096, 12'd249);
		query(12'd1159, -13'sd1, 12'd2500);
		query(12'd1700, 13'd4000, 12'd2749);
		query(12'd1031, 13'd999, 12'd2750);
		query(12'd2135, 13'd1000, 12'd2600);
		write_entry(7, 63, 15, 16'h1234);
		write_entry(2, 38, 3, 16'h5555);
		write_entry(0, 10, 11, 16'hAAAA);
		query(12'd1959, 13'd2500, 12'd100);
		drain();

		// Random phases; the register changes only between phases, with the block idle.
		for (int ph = 0; ph < 5; ph++) begin
			write_half_gap(gaps[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			n = 24;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(9) < 2)
					write_entry($urandom_range(7), $urandom_range(63), $urandom_range(15),
						16'($urandom));
				else
					random_query();
			end
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		if (sb.pending_answers.size() != 0) begin
			$error("%0d expected results never arrived", sb.pending_answers.size());
			sb.error_count++;
		end
		if (sb.error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/dtmi_pkg.sv
rtl/dtmi_ram.sv
rtl/drift_time_map_interpolator.sv
rtl/dtmi_checker.sv
test/drift_time_map_interpolator_tb.sv
